FILE: design/rmfp_pkg.sv
package rmfp_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int STORE_BYTES = 8192;

    localparam int AW   = $clog2(STORE_BYTES);
    localparam int CNTW = $clog2(STORE_BYTES + 1);

    localparam int GW   = 9;
    localparam int LW   = 11;
    localparam int CW   = 12;
    localparam int RBW  = 7;
    localparam int FAW  = 20;

    localparam int S_TDATA_W  = 56;
    localparam int S_TUSER_W  = 3;
    localparam int M_TDATA_W  = 8;
    localparam int M_TUSER_W  = 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [7:0] MASK_MSB = 8'h80;

    localparam logic [CFG_IDX_W-1:0] CFG_ROTATION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 2'd2;

    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_PLOT  = 2'd1,
        CMD_BLIT  = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [AW-1:0] addr;
        logic [7:0]    mask;
        logic          drop;
    } t_map;

    typedef struct packed {
        logic [GW-1:0]  eff_h;
        logic [RBW-1:0] rb;
    } t_geom;

endpackage

FILE: design/rotated_mono_framebuffer_plotter.sv
// A read issues one store read; a plot maps the pixel and, unless it is dropped, reads
// and writes back its byte; a blit does so for each of its eight pixels; a clear writes
// rows*bytes_per_row bytes, at most the whole store. One item is in work at a time,
// limited by the single read-modify-write port of the frame store; a result waits while
// the output register is full, and the next item is taken the cycle after it is loaded.
// Reset is synchronous, active low, and leaves the frame store as is.
module rotated_mono_framebuffer_plotter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // pos_x[8:0], pos_y[17:9], pixel_color[18], data_byte[26:19],
    // blit_height[35:27], byte_address[48:36], zero pad[55:49].
    input  logic [rmfp_pkg::S_TDATA_W-1:0]    i_s_tdata,
    // command[1:0], blit_start[2].
    input  logic [rmfp_pkg::S_TUSER_W-1:0]    i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // read_data[7:0].
    output logic [rmfp_pkg::M_TDATA_W-1:0]    o_m_tdata,
    // status[0].
    output logic [rmfp_pkg::M_TUSER_W-1:0]    o_m_tuser,
    input  logic                              i_cfg_we,
    input  logic [rmfp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rmfp_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);
    import rmfp_pkg::*;

    localparam logic [FAW-1:0]  STORE_C  = FAW'(STORE_BYTES);
    localparam logic [CNTW-1:0] STORE_CN = CNTW'(STORE_BYTES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLRSET,
        S_CLEAR,
        S_MAP,
        S_READ,
        S_MODIFY,
        S_RDISSUE,
        S_DONE
    } t_state;

    t_state         r_state;
    logic [1:0]     r_rotation;
    logic [GW-1:0]  r_width;
    logic [GW-1:0]  r_height;

    t_cmd           r_cmd;
    logic [8:0]     r_pos_x;
    logic [8:0]     r_pos_y;
    logic           r_color;
    logic [7:0]     r_data;
    logic [12:0]    r_baddr;

    logic [8:0]     r_cx;
    logic [9:0]     r_cy;
    logic [8:0]     r_oy;
    logic [8:0]     r_lh;
    logic [2:0]     r_t;

    t_map           r_map;
    logic           r_pcolor;
    logic [CNTW-1:0] r_cnt;
    logic [CNTW-1:0] r_total;
    logic [7:0]     r_rd;
    logic           r_st;

    logic           r_ovalid;
    logic [7:0]     r_odata;
    logic           r_ostatus;

    t_cmd           in_cmd;
    logic           in_start;
    logic           in_fire;
    logic [12:0]    in_baddr;
    logic [FAW-1:0] in_baddr_ext;
    logic [FAW-1:0] baddr_ext;

    logic [LW-1:0]  map_lx;
    logic [LW-1:0]  map_ly;
    t_map           map_out;
    t_geom          geom;
    logic           pcolor;
    logic           last_pixel;
    logic [FAW-1:0] clr_total;
    logic [9:0]     next_cy;
    logic [9:0]     cy_span;

    logic           ram_we;
    logic [AW-1:0]  ram_addr;
    logic [7:0]     ram_wdata;
    logic [7:0]     ram_rdata;

    assign in_cmd       = t_cmd'(i_s_tuser[1:0]);
    assign in_start     = i_s_tuser[2];
    assign in_baddr     = i_s_tdata[48:36];
    assign in_baddr_ext = FAW'(in_baddr);
    assign baddr_ext    = FAW'(r_baddr);
    assign o_s_tready   = (r_state == S_IDLE);
    assign in_fire      = i_s_tvalid && o_s_tready;

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ostatus;

    always_comb begin
        if (r_cmd == CMD_PLOT) begin
            map_lx = LW'(r_pos_x);
            map_ly = LW'(r_pos_y);
            pcolor = r_color;
        end else begin
            map_lx = LW'(r_cx);
            map_ly = LW'(r_cy) + LW'(r_t);
            pcolor = r_data[~r_t] ? r_color : ~r_color;
        end
        last_pixel = (r_cmd == CMD_PLOT) || (r_t == 3'd7);
        clr_total  = FAW'(geom.eff_h) * FAW'(geom.rb);
        next_cy    = r_cy + 10'd8;
        cy_span    = next_cy - {1'b0, r_oy};
    end

    rmfp_pixel_map u_map (
        .i_rotation (r_rotation),
        .i_width    (r_width),
        .i_height   (r_height),
        .i_lx       (map_lx),
        .i_ly       (map_ly),
        .o_map      (map_out),
        .o_geom     (geom)
    );

    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = r_map.addr;
        ram_wdata = r_pcolor ? (ram_rdata | r_map.mask) : (ram_rdata & ~r_map.mask);
        case (r_state)
            S_CLEAR: begin
                ram_we    = (r_cnt < r_total);
                ram_addr  = r_cnt[AW-1:0];
                ram_wdata = r_data;
            end
            S_RDISSUE, S_DONE: begin
                ram_addr = baddr_ext[AW-1:0];
            end
            S_MODIFY: begin
                ram_we = 1'b1;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    rmfp_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_rotation <= 2'd0;
            r_width    <= GW'(152);
            r_height   <= GW'(152);
            r_cx       <= '0;
            r_cy       <= '0;
            r_oy       <= '0;
            r_lh       <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ROTATION: r_rotation <= i_cfg_wdata[1:0];
                    CFG_WIDTH:    r_width    <= i_cfg_wdata[GW-1:0];
                    CFG_HEIGHT:   r_height   <= i_cfg_wdata[GW-1:0];
                    default: begin
                    end
                endcase
            end

            if (r_ovalid && i_m_tready && (r_state != S_DONE)) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_cmd   <= in_cmd;
                        r_pos_x <= i_s_tdata[8:0];
                        r_pos_y <= i_s_tdata[17:9];
                        r_color <= i_s_tdata[18];
                        r_data  <= i_s_tdata[26:19];
                        r_baddr <= in_baddr;
                        r_t     <= 3'd0;
                        r_rd    <= 8'd0;
                        r_st    <= 1'b0;
                        case (in_cmd)
                            CMD_CLEAR: r_state <= S_CLRSET;
                            CMD_PLOT:  r_state <= S_MAP;
                            CMD_BLIT: begin
                                if (in_start) begin
                                    r_cx <= i_s_tdata[8:0];
                                    r_cy <= {1'b0, i_s_tdata[17:9]};
                                    r_oy <= i_s_tdata[17:9];
                                    r_lh <= i_s_tdata[35:27];
                                end
                                r_state <= S_MAP;
                            end
                            default: begin
                                if (in_baddr_ext >= STORE_C) begin
                                    r_st    <= 1'b1;
                                    r_state <= S_DONE;
                                end else begin
                                    r_state <= S_RDISSUE;
                                end
                            end
                        endcase
                    end
                end
                S_CLRSET: begin
                    if (clr_total > STORE_C) begin
                        r_total <= STORE_CN;
                        r_st    <= 1'b1;
                    end else begin
                        r_total <= clr_total[CNTW-1:0];
                    end
                    r_cnt   <= '0;
                    r_state <= S_CLEAR;
                end
                S_CLEAR: begin
                    if (r_cnt < r_total) begin
                        r_cnt <= r_cnt + CNTW'(1);
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_MAP: begin
                    r_map    <= map_out;
                    r_pcolor <= pcolor;
                    if (map_out.drop) begin
                        r_st <= 1'b1;
                        if (last_pixel) begin
                            if (r_cmd == CMD_BLIT) begin
                                if (cy_span >= {1'b0, r_lh}) begin
                                    r_cy <= {1'b0, r_oy};
                                    r_cx <= r_cx + 9'd1;
                                end else begin
                                    r_cy <= next_cy;
                                end
                            end
                            r_state <= S_DONE;
                        end else begin
                            r_t <= r_t + 3'd1;
                        end
                    end else begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_MODIFY;
                end
                S_MODIFY: begin
                    if (last_pixel) begin
                        if (r_cmd == CMD_BLIT) begin
                            if (cy_span >= {1'b0, r_lh}) begin
                                r_cy <= {1'b0, r_oy};
                                r_cx <= r_cx + 9'd1;
                            end else begin
                                r_cy <= next_cy;
                            end
                        end
                        r_state <= S_DONE;
                    end else begin
                        r_t     <= r_t + 3'd1;
                        r_state <= S_MAP;
                    end
                end
                S_RDISSUE: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (r_cmd == CMD_READ && !r_st) begin
                        r_rd <= ram_rdata;
                    end
                    if (!r_ovalid || i_m_tready) begin
                        r_ovalid  <= 1'b1;
                        r_odata   <= (r_cmd == CMD_READ && !r_st) ? ram_rdata : r_rd;
                        r_ostatus <= r_st;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: design/rmfp_ram.sv
module rmfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/rmfp_pixel_map.sv
module rmfp_pixel_map (
    input  logic [1:0]              i_rotation,
    input  logic [rmfp_pkg::GW-1:0] i_width,
    input  logic [rmfp_pkg::GW-1:0] i_height,
    input  logic [rmfp_pkg::LW-1:0] i_lx,
    input  logic [rmfp_pkg::LW-1:0] i_ly,
    output rmfp_pkg::t_map          o_map,
    output rmfp_pkg::t_geom         o_geom
);
    import rmfp_pkg::*;

    localparam logic [CW-1:0]  MAXW_C  = CW'(MAX_WIDTH);
    localparam logic [CW-1:0]  MAXH_C  = CW'(MAX_HEIGHT);
    localparam logic [FAW-1:0] STORE_C = FAW'(STORE_BYTES);

    logic [CW-1:0]        w_ext;
    logic [CW-1:0]        h_ext;
    logic [CW-1:0]        w_sat;
    logic [CW-1:0]        h_sat;
    logic [GW-1:0]        eff_w;
    logic [GW-1:0]        eff_h;
    logic [GW:0]          w_round;
    logic [RBW-1:0]       rb;
    logic signed [CW-1:0] ws;
    logic signed [CW-1:0] hs;
    logic signed [CW-1:0] lxs;
    logic signed [CW-1:0] lys;
    logic signed [CW-1:0] rb8s;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic                 off_frame;
    logic [FAW-1:0]       row_base;
    logic [FAW-1:0]       addr_full;

    always_comb begin
        w_ext   = {{(CW-GW){1'b0}}, i_width};
        h_ext   = {{(CW-GW){1'b0}}, i_height};
        w_sat   = (w_ext > MAXW_C) ? MAXW_C : w_ext;
        h_sat   = (h_ext > MAXH_C) ? MAXH_C : h_ext;
        eff_w   = w_sat[GW-1:0];
        eff_h   = h_sat[GW-1:0];
        w_round = {1'b0, eff_w} + (GW+1)'(7);
        rb      = w_round[GW:3];

        ws   = $signed({{(CW-GW){1'b0}}, eff_w});
        hs   = $signed({{(CW-GW){1'b0}}, eff_h});
        lxs  = $signed({{(CW-LW){1'b0}}, i_lx});
        lys  = $signed({{(CW-LW){1'b0}}, i_ly});
        rb8s = $signed({{(CW-RBW-3){1'b0}}, rb, 3'b000});

        case (i_rotation)
            ROT_0: begin
                px = lxs;
                py = hs - lys - CW'(1);
            end
            ROT_90: begin
                px = ws - lys - CW'(1);
                py = hs - lxs - CW'(1);
            end
            ROT_180: begin
                px = ws - lxs - CW'(1);
                py = lys;
            end
            default: begin
                px = lys;
                py = lxs;
            end
        endcase

        off_frame = (px < 0) || (py < 0) || (px >= rb8s) || (py >= hs);
        row_base  = FAW'(py[CW-2:0]) * FAW'(rb);
        addr_full = FAW'(px[CW-2:3]) + row_base;

        o_map.drop = off_frame || (addr_full >= STORE_C);
        o_map.addr = addr_full[AW-1:0];
        o_map.mask = MASK_MSB >> px[2:0];

        o_geom.eff_h = eff_h;
        o_geom.rb    = rb;
    end

endmodule
